[hw/rtl/bnms_pkg.sv]
// Shared constants, controller states, datapath commands and status for box NMS.
package bnms_pkg;

    localparam int DEF_MAX_BOXES  = 64;
    localparam int DEF_COORD_BITS = 12;
    localparam int SCORE_BITS     = 16;
    localparam int THR_BITS       = 16;
    localparam logic [THR_BITS-1:0] THR_RESET = 16'd29491;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SCAN_INIT,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_SCAN_END,
        ST_FETCH_RD,
        ST_FETCH_CAP,
        ST_K_CHK,
        ST_K_RD,
        ST_K_OV,
        ST_K_MUL,
        ST_K_UNI,
        ST_K_CMP,
        ST_KEEP,
        ST_EMIT_LAST
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SCAN_INIT,
        OP_SCAN_RD,
        OP_SCAN_CMP,
        OP_FETCH_RD,
        OP_FETCH_CAP,
        OP_K_RD,
        OP_K_OV,
        OP_K_MUL,
        OP_K_UNI,
        OP_K_NEXT,
        OP_KEEP,
        OP_CLEAR
    } op_t;

    typedef struct packed {
        op_t  op;
        logic run_end;
    } cmd_t;

    typedef struct packed {
        logic found;
        logic scan_last;
        logic k_done;
        logic hit;
        logic pend_valid;
    } sts_t;

endpackage

[hw/rtl/bnms_if.sv]
// Channel interfaces: box input, kept-box output and threshold write.
interface bnms_box_if #(parameter int COORD_BITS = bnms_pkg::DEF_COORD_BITS);
    logic                            valid;
    logic                            ready;
    logic [COORD_BITS-1:0]           left_edge;
    logic [COORD_BITS-1:0]           top_edge;
    logic [COORD_BITS-1:0]           right_edge;
    logic [COORD_BITS-1:0]           bottom_edge;
    logic [bnms_pkg::SCORE_BITS-1:0] confidence;
    logic                            frame_end;
    modport source (output valid, left_edge, top_edge, right_edge, bottom_edge,
                    confidence, frame_end, input ready);
    modport sink (input valid, left_edge, top_edge, right_edge, bottom_edge,
                  confidence, frame_end, output ready);
endinterface

interface bnms_kept_if #(parameter int COORD_BITS = bnms_pkg::DEF_COORD_BITS);
    logic                            valid;
    logic                            ready;
    logic [COORD_BITS-1:0]           kept_left;
    logic [COORD_BITS-1:0]           kept_top;
    logic [COORD_BITS-1:0]           kept_right;
    logic [COORD_BITS-1:0]           kept_bottom;
    logic [bnms_pkg::SCORE_BITS-1:0] kept_score;
    logic                            run_end;
    logic                            overflowed;
    modport source (output valid, kept_left, kept_top, kept_right, kept_bottom,
                    kept_score, run_end, overflowed, input ready);
    modport sink (input valid, kept_left, kept_top, kept_right, kept_bottom,
                  kept_score, run_end, overflowed, output ready);
endinterface

interface bnms_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [bnms_pkg::THR_BITS-1:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

[hw/rtl/box_nms_suppress.sv]
// Top level of the greedy non-maximum suppression block.
// Boxes are taken one per cycle until the box marked frame_end; boxes past
// MAX_BOXES are dropped and flag overflowed on every result of that frame.
// Survivors then come out in falling score order (ties in arrival order),
// run_end on the last. Each pick scans the whole store, then checks the
// candidate against the boxes kept so far through the single IoU unit,
// stopping at the first whose IoU reaches the threshold. No input is taken
// during that phase. The threshold register may be written only while the
// block is idle.
module box_nms_suppress #(
    parameter int MAX_BOXES  = bnms_pkg::DEF_MAX_BOXES,
    parameter int COORD_BITS = bnms_pkg::DEF_COORD_BITS
) (
    input logic        clk,
    input logic        rst_n,
    bnms_box_if.sink   box,
    bnms_kept_if.source kept,
    bnms_cfg_if.sink   cfg
);

    bnms_pkg::cmd_t cmd;
    bnms_pkg::sts_t sts;

    assign cfg.ready = 1'b1;

    // sequencing
    bnms_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (box.valid),
        .in_last   (box.frame_end),
        .in_ready  (box.ready),
        .out_valid (kept.valid),
        .out_ready (kept.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // storage and arithmetic
    bnms_dp #(
        .MAX_BOXES  (MAX_BOXES),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_left    (box.left_edge),
        .in_top     (box.top_edge),
        .in_right   (box.right_edge),
        .in_bottom  (box.bottom_edge),
        .in_score   (box.confidence),
        .cfg_we     (cfg.valid),
        .cfg_data   (cfg.data),
        .out_left   (kept.kept_left),
        .out_top    (kept.kept_top),
        .out_right  (kept.kept_right),
        .out_bottom (kept.kept_bottom),
        .out_score  (kept.kept_score),
        .out_ovf    (kept.overflowed)
    );

    assign kept.run_end = cmd.run_end;

endmodule

[hw/rtl/bnms_dp.sv]
// Datapath: box store, kept list, score selection scan and IoU compare.
module bnms_dp #(
    parameter int MAX_BOXES  = bnms_pkg::DEF_MAX_BOXES,
    parameter int COORD_BITS = bnms_pkg::DEF_COORD_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  bnms_pkg::cmd_t                  cmd,
    output bnms_pkg::sts_t                  sts,
    input  logic [COORD_BITS-1:0]           in_left,
    input  logic [COORD_BITS-1:0]           in_top,
    input  logic [COORD_BITS-1:0]           in_right,
    input  logic [COORD_BITS-1:0]           in_bottom,
    input  logic [bnms_pkg::SCORE_BITS-1:0] in_score,
    input  logic                            cfg_we,
    input  logic [bnms_pkg::THR_BITS-1:0]   cfg_data,
    output logic [COORD_BITS-1:0]           out_left,
    output logic [COORD_BITS-1:0]           out_top,
    output logic [COORD_BITS-1:0]           out_right,
    output logic [COORD_BITS-1:0]           out_bottom,
    output logic [bnms_pkg::SCORE_BITS-1:0] out_score,
    output logic                            out_ovf
);

    localparam int CB     = COORD_BITS;
    localparam int SB     = bnms_pkg::SCORE_BITS;
    localparam int TB     = bnms_pkg::THR_BITS;
    localparam int AW     = $clog2(MAX_BOXES);
    localparam int CW     = $clog2(MAX_BOXES + 1);
    localparam int SPW    = CB + 1;
    localparam int AREA_W = 2 * SPW;
    localparam int UNI_W  = AREA_W + 1;
    localparam int EW     = SB + 4 * CB + AREA_W;
    // entry layout, low to high: area, bottom, right, top, left, score
    localparam int O_Y2 = AREA_W;
    localparam int O_X2 = O_Y2 + CB;
    localparam int O_Y1 = O_X2 + CB;
    localparam int O_X1 = O_Y1 + CB;
    localparam int O_SC = O_X1 + CB;

    function automatic logic [SPW-1:0] span(input logic [CB-1:0] lo, input logic [CB-1:0] hi);
        logic [SPW-1:0] r;
        r = (hi >= lo) ? ({1'b0, hi} - {1'b0, lo} + SPW'(1)) : '0;
        return r;
    endfunction

    // stores
    logic [EW-1:0] bmem [MAX_BOXES];
    logic [EW-1:0] kmem [MAX_BOXES];
    logic [EW-1:0] b_rdata_reg;
    logic [EW-1:0] k_rdata_reg;

    // control registers
    logic [CW-1:0] cnt_reg, kcnt_reg, j_reg, k_reg;
    logic          ovf_reg, found_reg, first_reg, pend_v_reg;
    logic [TB-1:0] thr_reg;

    // payload registers
    logic [SB-1:0]       best_s_reg, prev_s_reg;
    logic [AW-1:0]       best_i_reg, prev_i_reg;
    logic [EW-1:0]       cand_reg, pend_reg;
    logic [SPW-1:0]      w_reg, h_reg;
    logic [AREA_W-1:0]   inter_reg;
    logic [UNI_W+TB-1:0] prod_reg;
    logic [AREA_W+TB-1:0] ish_reg;
    logic                uz_reg;

    logic          full;
    logic [EW-1:0] new_entry;
    logic [AW-1:0] baddr;
    logic [SB-1:0] rd_score;
    logic          eligible, better;
    logic [CB-1:0] lo_x, hi_x, lo_y, hi_y;
    logic [UNI_W-1:0] uni;

    assign full = (cnt_reg == CW'(MAX_BOXES));

    // incoming entry with inclusive area
    always_comb
    begin
        new_entry = {in_score, in_left, in_top, in_right, in_bottom,
                     AREA_W'(span(in_left, in_right)) * AREA_W'(span(in_top, in_bottom))};
    end

    assign baddr = (cmd.op == bnms_pkg::OP_FETCH_RD) ? best_i_reg : j_reg[AW-1:0];

    // box store
    always_ff @(posedge clk)
    begin
        if (cmd.op == bnms_pkg::OP_LOAD && !full)
        begin
            bmem[cnt_reg[AW-1:0]] <= new_entry;
        end
        if (cmd.op == bnms_pkg::OP_SCAN_RD || cmd.op == bnms_pkg::OP_FETCH_RD)
        begin
            b_rdata_reg <= bmem[baddr];
        end
    end

    // kept list
    always_ff @(posedge clk)
    begin
        if (cmd.op == bnms_pkg::OP_KEEP)
        begin
            kmem[kcnt_reg[AW-1:0]] <= cand_reg;
        end
        if (cmd.op == bnms_pkg::OP_K_RD)
        begin
            k_rdata_reg <= kmem[k_reg[AW-1:0]];
        end
    end

    // scan ordering: next in (score falling, index rising) after the previous pick
    assign rd_score = b_rdata_reg[O_SC +: SB];
    always_comb
    begin
        eligible = first_reg || (rd_score < prev_s_reg) ||
                   ((rd_score == prev_s_reg) && (j_reg[AW-1:0] > prev_i_reg));
        better   = !found_reg || (rd_score > best_s_reg);
    end

    // overlap corners
    always_comb
    begin
        lo_x = (cand_reg[O_X1 +: CB] > k_rdata_reg[O_X1 +: CB]) ?
               cand_reg[O_X1 +: CB] : k_rdata_reg[O_X1 +: CB];
        hi_x = (cand_reg[O_X2 +: CB] < k_rdata_reg[O_X2 +: CB]) ?
               cand_reg[O_X2 +: CB] : k_rdata_reg[O_X2 +: CB];
        lo_y = (cand_reg[O_Y1 +: CB] > k_rdata_reg[O_Y1 +: CB]) ?
               cand_reg[O_Y1 +: CB] : k_rdata_reg[O_Y1 +: CB];
        hi_y = (cand_reg[O_Y2 +: CB] < k_rdata_reg[O_Y2 +: CB]) ?
               cand_reg[O_Y2 +: CB] : k_rdata_reg[O_Y2 +: CB];
        uni  = UNI_W'(cand_reg[AREA_W-1:0]) + UNI_W'(k_rdata_reg[AREA_W-1:0])
               - UNI_W'(inter_reg);
    end

    // IoU arithmetic, one step per state
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            bnms_pkg::OP_K_OV:
            begin
                w_reg <= span(lo_x, hi_x);
                h_reg <= span(lo_y, hi_y);
            end
            bnms_pkg::OP_K_MUL:
            begin
                inter_reg <= AREA_W'(w_reg) * AREA_W'(h_reg);
            end
            bnms_pkg::OP_K_UNI:
            begin
                prod_reg <= (UNI_W + TB)'(thr_reg) * (UNI_W + TB)'(uni);
                ish_reg  <= {inter_reg, {TB{1'b0}}};
                uz_reg   <= (uni == '0);
            end
            default:
            begin
            end
        endcase
    end

    // selection payload
    always_ff @(posedge clk)
    begin
        if (cmd.op == bnms_pkg::OP_SCAN_CMP && eligible && better)
        begin
            best_s_reg <= rd_score;
            best_i_reg <= j_reg[AW-1:0];
        end
        if (cmd.op == bnms_pkg::OP_FETCH_CAP)
        begin
            cand_reg   <= b_rdata_reg;
            prev_s_reg <= best_s_reg;
            prev_i_reg <= best_i_reg;
        end
        if (cmd.op == bnms_pkg::OP_KEEP)
        begin
            pend_reg <= cand_reg;
        end
    end

    // threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= bnms_pkg::THR_RESET;
        end
        else if (cfg_we)
        begin
            thr_reg <= cfg_data;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            kcnt_reg   <= '0;
            j_reg      <= '0;
            k_reg      <= '0;
            ovf_reg    <= 1'b0;
            found_reg  <= 1'b0;
            first_reg  <= 1'b1;
            pend_v_reg <= 1'b0;
        end
        else
        begin
            unique case (cmd.op)
                bnms_pkg::OP_LOAD:
                begin
                    if (full)
                    begin
                        ovf_reg <= 1'b1;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                end
                bnms_pkg::OP_SCAN_INIT:
                begin
                    j_reg     <= '0;
                    found_reg <= 1'b0;
                end
                bnms_pkg::OP_SCAN_CMP:
                begin
                    j_reg <= j_reg + CW'(1);
                    if (eligible && better)
                    begin
                        found_reg <= 1'b1;
                    end
                end
                bnms_pkg::OP_FETCH_CAP:
                begin
                    first_reg <= 1'b0;
                    k_reg     <= '0;
                end
                bnms_pkg::OP_K_NEXT:
                begin
                    k_reg <= k_reg + CW'(1);
                end
                bnms_pkg::OP_KEEP:
                begin
                    kcnt_reg   <= kcnt_reg + CW'(1);
                    pend_v_reg <= 1'b1;
                end
                bnms_pkg::OP_CLEAR:
                begin
                    cnt_reg    <= '0;
                    kcnt_reg   <= '0;
                    ovf_reg    <= 1'b0;
                    first_reg  <= 1'b1;
                    pend_v_reg <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // status
    always_comb
    begin
        sts.found      = found_reg;
        sts.scan_last  = ((j_reg + CW'(1)) == cnt_reg);
        sts.k_done     = (k_reg == kcnt_reg);
        sts.hit        = !uz_reg && ({1'b0, ish_reg} >= prod_reg);
        sts.pend_valid = pend_v_reg;
    end

    // result payload
    assign out_left   = pend_reg[O_X1 +: CB];
    assign out_top    = pend_reg[O_Y1 +: CB];
    assign out_right  = pend_reg[O_X2 +: CB];
    assign out_bottom = pend_reg[O_Y2 +: CB];
    assign out_score  = pend_reg[O_SC +: SB];
    assign out_ovf    = ovf_reg;

endmodule

[hw/rtl/bnms_ctrl.sv]
// Controller: sequences loading, selection scans, overlap checks and output.
module bnms_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_last,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    output bnms_pkg::cmd_t cmd,
    input  bnms_pkg::sts_t sts
);

    bnms_pkg::state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bnms_pkg::ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bnms_pkg::ST_LOAD:
            begin
                if (in_valid && in_last)
                begin
                    state_next = bnms_pkg::ST_SCAN_INIT;
                end
            end
            bnms_pkg::ST_SCAN_INIT: state_next = bnms_pkg::ST_SCAN_RD;
            bnms_pkg::ST_SCAN_RD:   state_next = bnms_pkg::ST_SCAN_CMP;
            bnms_pkg::ST_SCAN_CMP:
            begin
                state_next = sts.scan_last ? bnms_pkg::ST_SCAN_END : bnms_pkg::ST_SCAN_RD;
            end
            bnms_pkg::ST_SCAN_END:
            begin
                state_next = sts.found ? bnms_pkg::ST_FETCH_RD : bnms_pkg::ST_EMIT_LAST;
            end
            bnms_pkg::ST_FETCH_RD:  state_next = bnms_pkg::ST_FETCH_CAP;
            bnms_pkg::ST_FETCH_CAP: state_next = bnms_pkg::ST_K_CHK;
            bnms_pkg::ST_K_CHK:
            begin
                state_next = sts.k_done ? bnms_pkg::ST_KEEP : bnms_pkg::ST_K_RD;
            end
            bnms_pkg::ST_K_RD:  state_next = bnms_pkg::ST_K_OV;
            bnms_pkg::ST_K_OV:  state_next = bnms_pkg::ST_K_MUL;
            bnms_pkg::ST_K_MUL: state_next = bnms_pkg::ST_K_UNI;
            bnms_pkg::ST_K_UNI: state_next = bnms_pkg::ST_K_CMP;
            bnms_pkg::ST_K_CMP:
            begin
                state_next = sts.hit ? bnms_pkg::ST_SCAN_INIT : bnms_pkg::ST_K_CHK;
            end
            bnms_pkg::ST_KEEP:
            begin
                if (!sts.pend_valid || out_ready)
                begin
                    state_next = bnms_pkg::ST_SCAN_INIT;
                end
            end
            bnms_pkg::ST_EMIT_LAST:
            begin
                if (out_ready)
                begin
                    state_next = bnms_pkg::ST_LOAD;
                end
            end
            default: state_next = bnms_pkg::ST_LOAD;
        endcase
    end

    // outputs and datapath commands
    always_comb
    begin
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        cmd.op      = bnms_pkg::OP_NONE;
        cmd.run_end = 1'b0;
        unique case (state_reg)
            bnms_pkg::ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op = bnms_pkg::OP_LOAD;
                end
            end
            bnms_pkg::ST_SCAN_INIT: cmd.op = bnms_pkg::OP_SCAN_INIT;
            bnms_pkg::ST_SCAN_RD:   cmd.op = bnms_pkg::OP_SCAN_RD;
            bnms_pkg::ST_SCAN_CMP:  cmd.op = bnms_pkg::OP_SCAN_CMP;
            bnms_pkg::ST_FETCH_RD:  cmd.op = bnms_pkg::OP_FETCH_RD;
            bnms_pkg::ST_FETCH_CAP: cmd.op = bnms_pkg::OP_FETCH_CAP;
            bnms_pkg::ST_K_RD:      cmd.op = bnms_pkg::OP_K_RD;
            bnms_pkg::ST_K_OV:      cmd.op = bnms_pkg::OP_K_OV;
            bnms_pkg::ST_K_MUL:     cmd.op = bnms_pkg::OP_K_MUL;
            bnms_pkg::ST_K_UNI:     cmd.op = bnms_pkg::OP_K_UNI;
            bnms_pkg::ST_K_CMP:
            begin
                if (!sts.hit)
                begin
                    cmd.op = bnms_pkg::OP_K_NEXT;
                end
            end
            bnms_pkg::ST_KEEP:
            begin
                // previous survivor leaves before the new one takes its place
                out_valid = sts.pend_valid;
                if (!sts.pend_valid || out_ready)
                begin
                    cmd.op = bnms_pkg::OP_KEEP;
                end
            end
            bnms_pkg::ST_EMIT_LAST:
            begin
                out_valid   = 1'b1;
                cmd.run_end = 1'b1;
                if (out_ready)
                begin
                    cmd.op = bnms_pkg::OP_CLEAR;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule
